### hw/rtl/ita_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII formatter.
`default_nettype none
package ita_pkg;

	typedef enum logic [1:0] {
		OP_DEC    = 2'd0,
		OP_HEX_LO = 2'd1,
		OP_HEX_UP = 2'd2,
		OP_PTR    = 2'd3
	} ita_op_t;

	typedef struct packed {
		ita_op_t     op;
		logic [63:0] value;
		logic        with_prefix;
	} ita_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last;
	} ita_result_t;

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		ita_op_t     op;
		logic [63:0] value;
		logic        prefix;
		logic [3:0]  top_idx;
	} ita_cmd_t;

	localparam int unsigned NIBBLES = 16;
	localparam int unsigned QDEPTH = 2;

	// floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit v.
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_X    = 8'h78;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] TEN       = 8'd10;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		base = upper ? CHAR_A_UP : CHAR_A_LO;
		if ({4'b0, d} < TEN) begin
			digit_char = CHAR_ZERO + {4'b0, d};
		end else begin
			digit_char = base + {4'b0, d} - TEN;
		end
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ita_front.sv
// Front end: masks the value, applies the prefix rule and finds the top hex digit.
`default_nettype none
module ita_front
	import ita_pkg::*;
(
	input  ita_item_t item,
	output ita_cmd_t  cmd
);

	logic [63:0] val_m;
	logic [3:0]  top;

	assign val_m = (item.op == OP_PTR) ? item.value : {32'b0, item.value[31:0]};

	// Highest nonzero nibble wins; an all-zero value keeps a single digit.
	always_comb begin
		top = 4'd0;
		for (int i = 0; i < NIBBLES; i++) begin
			if (val_m[4*i +: 4] != 4'd0) begin
				top = 4'(i);
			end
		end
	end

	assign cmd.op      = item.op;
	assign cmd.value   = val_m;
	assign cmd.prefix  = item.with_prefix & (item.op == OP_PTR);
	assign cmd.top_idx = top;

endmodule
`default_nettype wire

### hw/rtl/ita_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module ita_queue
	import ita_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ita_cmd_t push_cmd,
	input  logic     pop,
	output logic     q_valid,
	output ita_cmd_t q_cmd,
	output logic     full
);

	ita_cmd_t   mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign q_valid = (count_q != 2'd0);
	assign full    = (count_q == 2'(QDEPTH));
	assign q_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ita_back.sv
// Back end: decimal digit extraction, prefix and character emission.
`default_nettype none
module ita_back
	import ita_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  ita_cmd_t    q_cmd,
	output logic        pop,
	output logic        valid,
	output ita_result_t result
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_MUL  = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_PFX0 = 6'b001000,
		ST_PFX1 = 6'b010000,
		ST_EMIT = 6'b100000
	} ita_state_t;

	ita_state_t  state_q;
	logic [3:0]  dig_q [NIBBLES];
	logic [31:0] val_q;
	logic [63:0] prod_q;
	logic [3:0]  cnt_q;
	logic [3:0]  idx_q;
	logic        upper_q;
	logic        valid_q;
	ita_result_t result_q;

	logic [28:0] quo;
	logic [32:0] quo_x10;
	logic [31:0] rem;

	assign quo     = prod_q[63:DIV10_SHIFT];
	assign quo_x10 = {1'b0, quo, 3'b0} + {3'b0, quo, 1'b0};
	assign rem     = val_q - quo_x10[31:0];

	assign pop    = (state_q == ST_IDLE) && q_valid;
	assign valid  = valid_q;
	assign result = result_q;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					val_q   <= q_cmd.value[31:0];
					cnt_q   <= 4'd0;
					idx_q   <= q_cmd.top_idx;
					upper_q <= (q_cmd.op == OP_HEX_UP);
					if (q_cmd.op != OP_DEC) begin
						for (int i = 0; i < NIBBLES; i++) begin
							dig_q[i] <= q_cmd.value[4*i +: 4];
						end
					end
				end
			end
			ST_MUL: begin
				prod_q <= val_q * DIV10_RECIP;
			end
			ST_DIV: begin
				// Decimal digits land least significant first and are read back in reverse.
				dig_q[cnt_q] <= rem[3:0];
				cnt_q        <= cnt_q + 4'd1;
				val_q        <= {3'b0, quo};
				if (quo == 29'd0) begin
					idx_q <= cnt_q;
				end
			end
			ST_EMIT: begin
				idx_q <= idx_q - 4'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PFX0: result_q <= '{char_out: CHAR_ZERO, last: 1'b0};
			ST_PFX1: result_q <= '{char_out: CHAR_X, last: 1'b0};
			default: result_q <= '{char_out: digit_char(dig_q[idx_q], upper_q),
				last: (idx_q == 4'd0)};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= (state_q == ST_PFX0) || (state_q == ST_PFX1) ||
				(state_q == ST_EMIT);
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_cmd.op == OP_DEC) begin
							state_q <= ST_MUL;
						end else if (q_cmd.prefix) begin
							state_q <= ST_PFX0;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_MUL:  state_q <= ST_DIV;
				ST_DIV:  state_q <= (quo == 29'd0) ? ST_EMIT : ST_MUL;
				ST_PFX0: state_q <= ST_PFX1;
				ST_PFX1: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (idx_q == 4'd0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
//
// An item (op, value, with_prefix) is taken at a rising edge where start is high
// and busy is low. busy rises only when the two-entry command queue is full.
// Each character leaves on result for exactly one cycle with valid high; the
// final character of a number has result.last set. The receiver cannot stall:
// characters of one number come in consecutive cycles.
// A hex or pointer item goes from the queue straight to emission; the "0x"
// prefix, given only to pointer items that ask for it, comes first. Decimal
// digits come from a divide-by-ten unit built on a registered 32x32 reciprocal
// multiply, with one multiply state and one divide state per digit; all digits
// of a decimal number are found before its first character appears.
// The back end takes the next command from the queue only once it is idle
// again. A hex or pointer number has at most 18 characters, a decimal number
// at most 10.
// Reset empties the queue and returns the sequencer to idle; no character is
// in flight afterwards.
`default_nettype none
module integer_to_ascii_formatter
	import ita_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  ita_item_t   item,
	output logic        valid,
	output ita_result_t result
);

	ita_cmd_t front_cmd;
	ita_cmd_t q_cmd;
	logic     q_valid;
	logic     q_full;
	logic     push;
	logic     pop;

	assign busy = q_full;
	assign push = start & ~q_full;

	ita_front u_front (
		.item (item),
		.cmd  (front_cmd)
	);

	ita_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.full     (q_full)
	);

	ita_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.valid   (valid),
		.result  (result)
	);

endmodule
`default_nettype wire

### hw/rtl/ita_checker.sv
// Port-level checker for the formatter, bound to the top level.
`default_nettype none
module ita_checker
	import ita_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input ita_result_t result
);

	logic [7:0] c;
	assign c = result.char_out;

	// Only digits, hex letters and the prefix letter ever leave the block.
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46) || c == CHAR_X))
		else $error("character outside the output set");

	// A number's characters come in an unbroken run of beats.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last |=> valid)
		else $error("gap inside a number");

	// The prefix letter follows a non-final zero and is never final itself.
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		valid && c == CHAR_X |-> !result.last && $past(valid) &&
			$past(result.char_out) == CHAR_ZERO && !$past(result.last))
		else $error("misplaced prefix");

	// A new number never begins with a zero unless it is a lone zero or the start of the prefix.
	a_lead: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (!$past(valid) || $past(result.last)) && c == CHAR_ZERO |->
			(result.last or ##1 (result.char_out == CHAR_X)))
		else $error("leading zero");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (valid),
	.result (result)
);
`default_nettype wire

### tb/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for the integer to ASCII formatter.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
	import ita_pkg::*;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_X    = 8'h78;
	localparam logic [7:0] ASCII_LO_A = 8'h61;
	localparam logic [7:0] ASCII_UP_A = 8'h41;
	localparam int unsigned RANDOM_ITEMS = 128;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 100000;

	// Holds the characters each accepted number should produce, oldest first.
	class char_scoreboard;
		ita_result_t expected_chars[$];
		int unsigned errors;
		int unsigned chars_checked;

		function new();
			errors = 0;
			chars_checked = 0;
		endfunction

		// Formats one number the way the block should and queues its characters.
		function void note_number(ita_item_t it);
			logic [63:0] v;
			logic [63:0] rem;
			logic [3:0]  nib;
			logic [7:0]  digs[20];
			int          nd;
			int          i;
			ita_result_t r;
			v = it.value;
			nd = 0;
			if (it.op != OP_PTR) begin
				v = {32'b0, v[31:0]};
			end
			if (v == 64'd0) begin
				digs[0] = ASCII_ZERO;
				nd = 1;
			end else if (it.op == OP_DEC) begin
				while (v != 64'd0) begin
					rem = v % 64'd10;
					digs[nd] = ASCII_ZERO + rem[7:0];
					v = v / 64'd10;
					nd = nd + 1;
				end
			end else begin
				while (v != 64'd0) begin
					nib = v[3:0];
					if (nib < 4'd10) begin
						digs[nd] = ASCII_ZERO + {4'b0, nib};
					end else begin
						digs[nd] = ((it.op == OP_HEX_UP) ? ASCII_UP_A : ASCII_LO_A)
							+ {4'b0, nib} - 8'd10;
					end
					v = v >> 4;
					nd = nd + 1;
				end
			end
			if (it.op == OP_PTR && it.with_prefix) begin
				r.char_out = ASCII_ZERO;
				r.last = 1'b0;
				expected_chars.push_back(r);
				r.char_out = ASCII_X;
				expected_chars.push_back(r);
			end
			for (i = nd - 1; i >= 0; i--) begin
				r.char_out = digs[i];
				r.last = (i == 0);
				expected_chars.push_back(r);
			end
		endfunction

		function void check_char(ita_result_t got);
			ita_result_t want;
			if (expected_chars.size() == 0) begin
				errors++;
				$display("%0t: unexpected character: expected none, got char %h last %b",
					$time, got.char_out, got.last);
			end else begin
				want = expected_chars.pop_front();
				if (got.char_out !== want.char_out || got.last !== want.last) begin
					errors++;
					$display("%0t: mismatch: expected char %h last %b, got char %h last %b",
						$time, want.char_out, want.last, got.char_out, got.last);
				end
			end
			chars_checked++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	ita_item_t   item;
	logic        valid;
	ita_result_t result;

	char_scoreboard chars;
	int unsigned    cycles;
	int unsigned    numbers_per_op[4];

	integer_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.valid  (valid),
		.result (result)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d characters outstanding", $time,
				chars.expected_chars.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Beats are taken on the rising edge; outputs are still pre-edge values here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				chars.note_number(item);
				numbers_per_op[item.op]++;
			end
			if (valid) begin
				chars.check_char(result);
			end
		end
	end

	task automatic send_item(input ita_op_t op, input logic [63:0] value, input logic pfx);
		@(negedge clk);
		start <= 1'b1;
		item.op <= op;
		item.value <= value;
		item.with_prefix <= pfx;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
	endtask

	task automatic idle(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic drain();
		while (chars.expected_chars.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned burst;
		int unsigned bits;
		logic [63:0] raw;
		ita_op_t     op;
		bit          paused;

		chars = new();
		numbers_per_op = '{0, 0, 0, 0};
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		sent = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		idle(2);

		// Field extremes, every mode, zero with and without prefix, ignored bits.
		send_item(OP_DEC, 64'd0, 1'b0);
		send_item(OP_DEC, 64'd1, 1'b1);
		send_item(OP_DEC, 64'd9, 1'b0);
		send_item(OP_DEC, 64'd10, 1'b0);
		send_item(OP_DEC, 64'd1000000000, 1'b0);
		send_item(OP_DEC, 64'hFFFF_FFFF, 1'b0);
		send_item(OP_DEC, 64'hFFFF_FFFF_0000_0000, 1'b1);
		send_item(OP_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_item(OP_HEX_LO, 64'd0, 1'b0);
		send_item(OP_HEX_LO, 64'hDEAD_BEEF, 1'b0);
		send_item(OP_HEX_LO, 64'h1234_5678_FFFF_FFFF, 1'b1);
		send_item(OP_HEX_LO, 64'hFFFF_FFFF_0000_0000, 1'b0);
		send_item(OP_HEX_UP, 64'd0, 1'b1);
		send_item(OP_HEX_UP, 64'hABCD_EF01, 1'b0);
		send_item(OP_HEX_UP, 64'h0000_000F, 1'b0);
		send_item(OP_HEX_UP, 64'h8000_0000_8000_0000, 1'b1);
		send_item(OP_PTR, 64'd0, 1'b0);
		send_item(OP_PTR, 64'd0, 1'b1);
		send_item(OP_PTR, 64'd1, 1'b1);
		send_item(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_item(OP_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_item(OP_PTR, 64'h8000_0000_0000_0000, 1'b0);
		send_item(OP_PTR, 64'h0123_4567_89AB_CDEF, 1'b1);
		idle(1);
		drain();

		// Random numbers in bursts; lengths vary so short and long outputs both show up.
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				op = ita_op_t'($urandom_range(0, 3));
				raw = {$urandom(), $urandom()};
				if ($urandom_range(0, 3) != 0) begin
					bits = $urandom_range(0, 63);
					raw = raw & ((64'd1 << bits) - 64'd1);
					if (op != OP_PTR && $urandom_range(0, 3) == 0) begin
						raw[63:32] = $urandom();
					end
				end
				send_item(op, raw, 1'($urandom_range(0, 1)));
				sent++;
			end
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				idle(1);
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 3) != 0) begin
				idle($urandom_range(1, 8));
			end
		end
		idle(1);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Formatted %0d decimal, %0d lower hex, %0d upper hex, %0d pointer numbers;",
			numbers_per_op[OP_DEC], numbers_per_op[OP_HEX_LO],
			numbers_per_op[OP_HEX_UP], numbers_per_op[OP_PTR]);
		$display("%0d characters compared, %0d mismatches.", chars.chars_checked, chars.errors);
		if (chars.errors == 0 && chars.expected_chars.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### integer_to_ascii_formatter.f
hw/rtl/ita_pkg.sv
hw/rtl/ita_front.sv
hw/rtl/ita_queue.sv
hw/rtl/ita_back.sv
hw/rtl/integer_to_ascii_formatter.sv
hw/rtl/ita_checker.sv
tb/integer_to_ascii_formatter_tb.sv
